// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bilinear_crop_resize check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bilinear_crop_resize check failed");

`endif

// ===== hdl/bcr_pkg.sv =====
`default_nettype none
package bcr_pkg;

  localparam int STORE_BYTES = 65536;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int MAX_DIM     = 1024;
  localparam int DIM_W       = 11;
  localparam int COORD_W     = $clog2(MAX_DIM);
  localparam int WEIGHT_BITS = 12;
  localparam int DIV_STEPS   = COORD_W + WEIGHT_BITS;
  localparam int NUM_W       = 2 * DIM_W + 1;
  localparam int DEN_W       = DIM_W + 1;
  localparam int REM_W       = NUM_W - COORD_W;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int CH_W        = 3;
  localparam int CHAN_W      = 2;
  localparam int MAX_CH      = 4;
  localparam int BYTE_W      = 8;
  localparam int FULL_ADDR_W = PROD_W + CH_W;
  localparam int NBR         = 4;
  localparam int NBR_W       = 2;
  localparam int WGT_W       = WEIGHT_BITS + 1;
  localparam int ONE         = 1 << WEIGHT_BITS;
  localparam int SHIFT       = 2 * WEIGHT_BITS;
  localparam int ROW_W       = BYTE_W + WEIGHT_BITS + 1;
  localparam int PIX_W       = ROW_W + WGT_W;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int COL_W       = 10;
  localparam int SIDX_W      = 16;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_SRC_H  = 3'd0,
    REG_SRC_W  = 3'd1,
    REG_CHN    = 3'd2,
    REG_RSZ_H  = 3'd3,
    REG_RSZ_W  = 3'd4,
    REG_CROP_H = 3'd5,
    REG_CROP_W = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] src_w;
    logic [CH_W-1:0]  chn;
    logic [DIM_W-1:0] rsz_h;
    logic [DIM_W-1:0] rsz_w;
    logic [DIM_W-1:0] crop_h;
    logic [DIM_W-1:0] crop_w;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [SIDX_W-1:0] sidx;
    logic [BYTE_W-1:0] sbyte;
    logic              err;
    logic [CHAN_W-1:0] ch;
  } side_t;

  typedef struct packed {
    op_t                             op;
    logic [SIDX_W-1:0]               sidx;
    logic [BYTE_W-1:0]               sbyte;
    logic                            err;
    logic [NBR-1:0][ADDR_W-1:0]      addr;
    logic [WEIGHT_BITS-1:0]          fx;
    logic [WEIGHT_BITS-1:0]          fy;
  } cmd_t;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (d <= DIM_W'(MAX_DIM));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bcr_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per pipeline stage.
module bcr_divider (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [bcr_pkg::NUM_W-1:0]       num,
  input  wire logic [bcr_pkg::DEN_W-1:0]       den,
  output logic      [bcr_pkg::DIV_STEPS-1:0]   quo
);

  logic [bcr_pkg::REM_W-1:0]     rem_r  [bcr_pkg::DIV_STEPS];
  logic [bcr_pkg::DIV_STEPS-1:0] rest_r [bcr_pkg::DIV_STEPS];
  logic [bcr_pkg::DIV_STEPS-1:0] quo_r  [bcr_pkg::DIV_STEPS];
  logic [bcr_pkg::DEN_W-1:0]     den_r  [bcr_pkg::DIV_STEPS];

  logic [bcr_pkg::REM_W-1:0]     rem_nxt  [bcr_pkg::DIV_STEPS];
  logic [bcr_pkg::DIV_STEPS-1:0] rest_nxt [bcr_pkg::DIV_STEPS];
  logic [bcr_pkg::DIV_STEPS-1:0] quo_nxt  [bcr_pkg::DIV_STEPS];
  logic [bcr_pkg::DEN_W-1:0]     den_nxt  [bcr_pkg::DIV_STEPS];

  always_comb begin
    logic [bcr_pkg::REM_W-1:0]     rem_in;
    logic [bcr_pkg::DIV_STEPS-1:0] rest_in;
    logic [bcr_pkg::DIV_STEPS-1:0] quo_in;
    logic [bcr_pkg::DEN_W-1:0]     den_in;
    logic [bcr_pkg::REM_W:0]       trial;
    logic                          take;
    for (int i = 0; i < bcr_pkg::DIV_STEPS; i++) begin
      if (i == 0) begin
        rem_in  = num[bcr_pkg::NUM_W-1:bcr_pkg::COORD_W];
        rest_in = {num[bcr_pkg::COORD_W-1:0], {bcr_pkg::WEIGHT_BITS{1'b0}}};
        quo_in  = '0;
        den_in  = den;
      end else begin
        rem_in  = rem_r[i-1];
        rest_in = rest_r[i-1];
        quo_in  = quo_r[i-1];
        den_in  = den_r[i-1];
      end
      trial = {rem_in, rest_in[bcr_pkg::DIV_STEPS-1]};
      take  = trial >= (bcr_pkg::REM_W+1)'(den_in);
      if (take) begin
        rem_nxt[i] = bcr_pkg::REM_W'(trial - (bcr_pkg::REM_W+1)'(den_in));
      end else begin
        rem_nxt[i] = trial[bcr_pkg::REM_W-1:0];
      end
      rest_nxt[i] = {rest_in[bcr_pkg::DIV_STEPS-2:0], 1'b0};
      quo_nxt[i]  = {quo_in[bcr_pkg::DIV_STEPS-2:0], take};
      den_nxt[i]  = den_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < bcr_pkg::DIV_STEPS; i++) begin
        rem_r[i]  <= rem_nxt[i];
        rest_r[i] <= rest_nxt[i];
        quo_r[i]  <= quo_nxt[i];
        den_r[i]  <= den_nxt[i];
      end
    end
  end

  assign quo = quo_r[bcr_pkg::DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== hdl/bcr_front.sv =====
`default_nettype none
// Accepts items, checks geometry, maps coordinates and forms store addresses.
module bcr_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bcr_pkg::cfg_t                cfg,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         in_opcode,
  input  wire logic [bcr_pkg::SIDX_W-1:0]   in_source_index,
  input  wire logic [bcr_pkg::BYTE_W-1:0]   in_source_byte,
  input  wire logic [bcr_pkg::COL_W-1:0]    in_crop_column,
  input  wire logic [bcr_pkg::COL_W-1:0]    in_crop_row,
  input  wire logic [bcr_pkg::CHAN_W-1:0]   in_channel,
  output logic                              cmd_valid,
  output bcr_pkg::cmd_t                     cmd,
  input  wire logic                         cmd_full
);

  logic adv;
  logic accept;
  logic geom_bad;
  logic req_bad;
  bcr_pkg::side_t side_nxt;
  logic [bcr_pkg::DIM_W-1:0] posx_nxt, posy_nxt;

  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic vd_r [bcr_pkg::DIV_STEPS];

  bcr_pkg::side_t side0_r, side1_r, side2_r, side3_r, side4_r;
  bcr_pkg::side_t sided_r [bcr_pkg::DIV_STEPS];
  logic negxd_r [bcr_pkg::DIV_STEPS];
  logic negyd_r [bcr_pkg::DIV_STEPS];

  logic [bcr_pkg::DIM_W-1:0]  posx0_r, posy0_r;
  logic [bcr_pkg::PROD_W-1:0] prodx1_r, prody1_r;
  logic [bcr_pkg::NUM_W-1:0]  numx2_r, numy2_r;
  logic                       negx2_r, negy2_r;
  logic [bcr_pkg::DIV_STEPS-1:0] qx, qy;

  logic [bcr_pkg::NUM_W-1:0] numx_full, numy_full;
  logic negx_nxt, negy_nxt;

  logic [bcr_pkg::DIM_W-1:0]       x1_nxt, x2_nxt, y1_nxt, y2_nxt;
  logic [bcr_pkg::WEIGHT_BITS-1:0] fx_nxt, fy_nxt;
  logic [bcr_pkg::DIM_W-1:0]       x1_3r, x2_3r, y1_3r, y2_3r;
  logic [bcr_pkg::WEIGHT_BITS-1:0] fx3_r, fy3_r;

  logic [bcr_pkg::PROD_W-1:0]      rowa4_r, rowb4_r;
  logic [bcr_pkg::DIM_W-1:0]       x1_4r, x2_4r;
  logic [bcr_pkg::WEIGHT_BITS-1:0] fx4_r, fy4_r;

  bcr_pkg::cmd_t cmd_nxt;
  bcr_pkg::cmd_t cmd5_r;

  assign adv    = !(v5_r && cmd_full);
  assign full   = !adv;
  assign accept = push && adv;

  always_comb begin
    geom_bad = !bcr_pkg::dim_ok(cfg.src_h) || !bcr_pkg::dim_ok(cfg.src_w) ||
               !bcr_pkg::dim_ok(cfg.rsz_h) || !bcr_pkg::dim_ok(cfg.rsz_w) ||
               !bcr_pkg::dim_ok(cfg.crop_h) || !bcr_pkg::dim_ok(cfg.crop_w) ||
               (cfg.chn == '0) || (cfg.chn > bcr_pkg::CH_W'(bcr_pkg::MAX_CH)) ||
               (cfg.crop_h > cfg.rsz_h) || (cfg.crop_w > cfg.rsz_w);
    req_bad  = (bcr_pkg::DIM_W'(in_crop_column) >= cfg.crop_w) ||
               (bcr_pkg::DIM_W'(in_crop_row) >= cfg.crop_h) ||
               (bcr_pkg::CH_W'(in_channel) >= cfg.chn);
    side_nxt.op    = bcr_pkg::op_t'(in_opcode);
    side_nxt.sidx  = in_source_index;
    side_nxt.sbyte = in_source_byte;
    side_nxt.err   = (bcr_pkg::op_t'(in_opcode) == bcr_pkg::OP_REQUEST) &&
                     (geom_bad || req_bad);
    side_nxt.ch    = in_channel;
    posx_nxt = bcr_pkg::DIM_W'(in_crop_column) + ((cfg.rsz_w - cfg.crop_w) >> 1);
    posy_nxt = bcr_pkg::DIM_W'(in_crop_row) + ((cfg.rsz_h - cfg.crop_h) >> 1);
  end

  always_comb begin
    numx_full = {prodx1_r, 1'b0} + bcr_pkg::NUM_W'(cfg.src_w);
    numy_full = {prody1_r, 1'b0} + bcr_pkg::NUM_W'(cfg.src_h);
    negx_nxt  = numx_full < bcr_pkg::NUM_W'(cfg.rsz_w);
    negy_nxt  = numy_full < bcr_pkg::NUM_W'(cfg.rsz_h);
  end

  bcr_divider u_divx (
    .clk (clk),
    .en  (adv),
    .num (numx2_r),
    .den ({cfg.rsz_w, 1'b0}),
    .quo (qx)
  );

  bcr_divider u_divy (
    .clk (clk),
    .en  (adv),
    .num (numy2_r),
    .den ({cfg.rsz_h, 1'b0}),
    .quo (qy)
  );

  always_comb begin
    logic [bcr_pkg::DIM_W-1:0] xinc, yinc;
    if (negxd_r[bcr_pkg::DIV_STEPS-1]) begin
      x1_nxt = '0;
      fx_nxt = '0;
    end else begin
      x1_nxt = bcr_pkg::DIM_W'(qx[bcr_pkg::DIV_STEPS-1:bcr_pkg::WEIGHT_BITS]);
      fx_nxt = qx[bcr_pkg::WEIGHT_BITS-1:0];
    end
    if (negyd_r[bcr_pkg::DIV_STEPS-1]) begin
      y1_nxt = '0;
      fy_nxt = '0;
    end else begin
      y1_nxt = bcr_pkg::DIM_W'(qy[bcr_pkg::DIV_STEPS-1:bcr_pkg::WEIGHT_BITS]);
      fy_nxt = qy[bcr_pkg::WEIGHT_BITS-1:0];
    end
    xinc   = x1_nxt + bcr_pkg::DIM_W'(1);
    yinc   = y1_nxt + bcr_pkg::DIM_W'(1);
    x2_nxt = (xinc >= cfg.src_w) ? cfg.src_w - bcr_pkg::DIM_W'(1) : xinc;
    y2_nxt = (yinc >= cfg.src_h) ? cfg.src_h - bcr_pkg::DIM_W'(1) : yinc;
  end

  always_comb begin
    logic [bcr_pkg::FULL_ADDR_W-1:0] full_a;
    logic [bcr_pkg::PROD_W-1:0]      row_sel;
    logic [bcr_pkg::DIM_W-1:0]       x_sel;
    logic                            oos;
    cmd_nxt.op    = side4_r.op;
    cmd_nxt.sidx  = side4_r.sidx;
    cmd_nxt.sbyte = side4_r.sbyte;
    cmd_nxt.fx    = fx4_r;
    cmd_nxt.fy    = fy4_r;
    oos = 1'b0;
    for (int k = 0; k < bcr_pkg::NBR; k++) begin
      row_sel = k[1] ? rowb4_r : rowa4_r;
      x_sel   = k[0] ? x2_4r : x1_4r;
      full_a  = (bcr_pkg::FULL_ADDR_W'(row_sel) + bcr_pkg::FULL_ADDR_W'(x_sel)) *
                bcr_pkg::FULL_ADDR_W'(cfg.chn) + bcr_pkg::FULL_ADDR_W'(side4_r.ch);
      cmd_nxt.addr[k] = full_a[bcr_pkg::ADDR_W-1:0];
      oos = oos || (full_a[bcr_pkg::FULL_ADDR_W-1:bcr_pkg::ADDR_W] != '0);
    end
    cmd_nxt.err = side4_r.err ||
                  ((side4_r.op == bcr_pkg::OP_REQUEST) && oos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      for (int i = 0; i < bcr_pkg::DIV_STEPS; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (adv) begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
      for (int i = 0; i < bcr_pkg::DIV_STEPS; i++) begin
        vd_r[i] <= (i == 0) ? v2_r : vd_r[i-1];
      end
      v3_r <= vd_r[bcr_pkg::DIV_STEPS-1];
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side0_r  <= side_nxt;
      posx0_r  <= posx_nxt;
      posy0_r  <= posy_nxt;
      side1_r  <= side0_r;
      prodx1_r <= bcr_pkg::PROD_W'(cfg.src_w) * bcr_pkg::PROD_W'(posx0_r);
      prody1_r <= bcr_pkg::PROD_W'(cfg.src_h) * bcr_pkg::PROD_W'(posy0_r);
      side2_r  <= side1_r;
      negx2_r  <= negx_nxt;
      negy2_r  <= negy_nxt;
      numx2_r  <= negx_nxt ? '0 : numx_full - bcr_pkg::NUM_W'(cfg.rsz_w);
      numy2_r  <= negy_nxt ? '0 : numy_full - bcr_pkg::NUM_W'(cfg.rsz_h);
      for (int i = 0; i < bcr_pkg::DIV_STEPS; i++) begin
        sided_r[i] <= (i == 0) ? side2_r : sided_r[i-1];
        negxd_r[i] <= (i == 0) ? negx2_r : negxd_r[i-1];
        negyd_r[i] <= (i == 0) ? negy2_r : negyd_r[i-1];
      end
      side3_r <= sided_r[bcr_pkg::DIV_STEPS-1];
      x1_3r   <= x1_nxt;
      x2_3r   <= x2_nxt;
      y1_3r   <= y1_nxt;
      y2_3r   <= y2_nxt;
      fx3_r   <= fx_nxt;
      fy3_r   <= fy_nxt;
      side4_r <= side3_r;
      rowa4_r <= bcr_pkg::PROD_W'(y1_3r) * bcr_pkg::PROD_W'(cfg.src_w);
      rowb4_r <= bcr_pkg::PROD_W'(y2_3r) * bcr_pkg::PROD_W'(cfg.src_w);
      x1_4r   <= x1_3r;
      x2_4r   <= x2_3r;
      fx4_r   <= fx3_r;
      fy4_r   <= fy3_r;
      cmd5_r  <= cmd_nxt;
    end
  end

  assign cmd_valid = v5_r && !cmd_full;
  assign cmd       = cmd5_r;

endmodule
`default_nettype wire

// ===== hdl/bcr_fifo.sv =====
`default_nettype none
// Show-ahead command queue between the front and the back.
module bcr_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire bcr_pkg::cmd_t wr_data,
  output logic               q_full,
  input  wire logic          rd_en,
  output bcr_pkg::cmd_t      rd_data,
  output logic               q_empty
);

  bcr_pkg::cmd_t                 slot_r [bcr_pkg::FIFO_DEPTH];
  logic [bcr_pkg::FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [bcr_pkg::FIFO_CNT_W-1:0] cnt_r;
  logic do_wr, do_rd;

  assign q_full  = cnt_r == bcr_pkg::FIFO_CNT_W'(bcr_pkg::FIFO_DEPTH);
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + bcr_pkg::FIFO_PTR_W'(1);
      end
      if (do_rd) begin
        rp_r <= rp_r + bcr_pkg::FIFO_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + bcr_pkg::FIFO_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - bcr_pkg::FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bcr_back.sv =====
`default_nettype none
// Executes queued commands on the source store and blends the neighbors.
module bcr_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bcr_pkg::cmd_t               head,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [bcr_pkg::BYTE_W-1:0]       out_pixel_out,
  output logic                             out_error
);

  logic [bcr_pkg::BYTE_W-1:0] mem [bcr_pkg::STORE_BYTES];
  logic [bcr_pkg::BYTE_W-1:0] rdata_r;

  bcr_pkg::cmd_t cur_r;
  logic                      act_r;
  logic [bcr_pkg::NBR_W-1:0] k_r;
  logic                      rd_v_r;
  logic [bcr_pkg::NBR_W-1:0] rd_k_r;
  logic                      cap_v_r;
  logic [bcr_pkg::BYTE_W-1:0] nbr_r [bcr_pkg::NBR-1];

  logic                      b1_v_r;
  logic [bcr_pkg::ROW_W-1:0] r1_r, r2_r;
  logic [bcr_pkg::WEIGHT_BITS-1:0] fy1_r;
  logic                      err1_r;

  logic                      out_v_r;
  logic [bcr_pkg::BYTE_W-1:0] pix_r;
  logic                      oerr_r;

  logic out_load, b1_free, b1_load, can_pop, wr_en, req_start, rd_en;
  logic [bcr_pkg::ADDR_W-1:0] rd_addr;
  logic [bcr_pkg::NBR_W-1:0]  rd_k;
  logic [bcr_pkg::WGT_W-1:0]  wx0, wx1, wy0, wy1;
  logic [bcr_pkg::ROW_W-1:0]  r1_nxt, r2_nxt;
  logic [bcr_pkg::PIX_W-1:0]  p_nxt;

  localparam logic [bcr_pkg::NBR_W-1:0] LAST_K = bcr_pkg::NBR_W'(bcr_pkg::NBR - 1);

  assign out_load  = b1_v_r && (!out_v_r || pop);
  assign b1_free   = !b1_v_r || out_load;
  assign b1_load   = cap_v_r && b1_free;
  assign can_pop   = !q_empty && !act_r && (!cap_v_r || b1_load);
  assign q_pop     = can_pop;
  assign wr_en     = can_pop && (head.op == bcr_pkg::OP_WRITE);
  assign req_start = can_pop && (head.op == bcr_pkg::OP_REQUEST);
  assign rd_en     = req_start || act_r;
  assign rd_addr   = req_start ? head.addr[0] : cur_r.addr[k_r];
  assign rd_k      = req_start ? '0 : k_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head.sidx] <= head.sbyte;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      k_r     <= '0;
      rd_v_r  <= 1'b0;
      rd_k_r  <= '0;
      cap_v_r <= 1'b0;
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (req_start) begin
        act_r <= 1'b1;
        k_r   <= bcr_pkg::NBR_W'(1);
      end else if (act_r) begin
        k_r <= k_r + bcr_pkg::NBR_W'(1);
        if (k_r == LAST_K) begin
          act_r <= 1'b0;
        end
      end
      rd_v_r  <= rd_en;
      rd_k_r  <= rd_k;
      cap_v_r <= (rd_en && (rd_k == LAST_K)) || (cap_v_r && !b1_load);
      if (b1_load) begin
        b1_v_r <= 1'b1;
      end else if (out_load) begin
        b1_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_comb begin
    wx1    = bcr_pkg::WGT_W'(cur_r.fx);
    wx0    = bcr_pkg::WGT_W'(bcr_pkg::ONE) - wx1;
    r1_nxt = bcr_pkg::ROW_W'(nbr_r[0]) * bcr_pkg::ROW_W'(wx0) +
             bcr_pkg::ROW_W'(nbr_r[1]) * bcr_pkg::ROW_W'(wx1);
    r2_nxt = bcr_pkg::ROW_W'(nbr_r[2]) * bcr_pkg::ROW_W'(wx0) +
             bcr_pkg::ROW_W'(rdata_r) * bcr_pkg::ROW_W'(wx1);
    wy1    = bcr_pkg::WGT_W'(fy1_r);
    wy0    = bcr_pkg::WGT_W'(bcr_pkg::ONE) - wy1;
    p_nxt  = bcr_pkg::PIX_W'(r1_r) * bcr_pkg::PIX_W'(wy0) +
             bcr_pkg::PIX_W'(r2_r) * bcr_pkg::PIX_W'(wy1);
  end

  always_ff @(posedge clk) begin
    if (req_start) begin
      cur_r <= head;
    end
    if (rd_v_r && (rd_k_r != LAST_K)) begin
      nbr_r[rd_k_r] <= rdata_r;
    end
    if (b1_load) begin
      r1_r   <= r1_nxt;
      r2_r   <= r2_nxt;
      fy1_r  <= cur_r.fy;
      err1_r <= cur_r.err;
    end
    if (out_load) begin
      pix_r  <= err1_r ? '0 : p_nxt[bcr_pkg::SHIFT+bcr_pkg::BYTE_W-1:bcr_pkg::SHIFT];
      oerr_r <= err1_r;
    end
  end

  assign empty         = !out_v_r;
  assign out_pixel_out = pix_r;
  assign out_error     = oerr_r;

endmodule
`default_nettype wire

// ===== hdl/bilinear_crop_resize.sv =====
// Bilinear resize with a centered crop, one output byte per request.
// Input channel: push/full. in_opcode 0 writes in_source_byte to the source
// store at in_source_index; in_opcode 1 requests the crop pixel byte at
// in_crop_column, in_crop_row and in_channel. A write gives no result.
// Result channel: empty/pop. Each request yields one transfer with
// out_pixel_out and out_error; results leave in request order.
// The user must set geometry over the APB-style port before requests are
// issued; the block itself does not enforce this. A request passes six
// coordinate stages and a 22-stage divider, then four reads and two blend
// stages. Writes go one per cycle unless the pipeline stalls; a request
// holds the single-port source store for its four neighbor reads, one byte
// per cycle. A four-entry command queue sits between the address pipeline
// and the store; when the receiver stalls, the queue fills and full rises.
// Reset empties all pipelines and sets every geometry register to 1; the
// store contents are undefined until written.
`default_nettype none
module bilinear_crop_resize (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              in_opcode,
  input  wire logic [bcr_pkg::SIDX_W-1:0]        in_source_index,
  input  wire logic [bcr_pkg::BYTE_W-1:0]        in_source_byte,
  input  wire logic [bcr_pkg::COL_W-1:0]         in_crop_column,
  input  wire logic [bcr_pkg::COL_W-1:0]         in_crop_row,
  input  wire logic [bcr_pkg::CHAN_W-1:0]        in_channel,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [bcr_pkg::BYTE_W-1:0]             out_pixel_out,
  output logic                                   out_error,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bcr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [bcr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bcr_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  bcr_pkg::cfg_t    cfg_r;
  bcr_pkg::cfg_reg_t reg_sel;
  logic             cfg_wr;
  logic             cmd_valid;
  bcr_pkg::cmd_t    cmd;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  bcr_pkg::cmd_t    head;

  assign pready  = 1'b1;
  assign reg_sel = bcr_pkg::cfg_reg_t'(paddr[bcr_pkg::CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_h  <= bcr_pkg::DIM_W'(1);
      cfg_r.src_w  <= bcr_pkg::DIM_W'(1);
      cfg_r.chn    <= bcr_pkg::CH_W'(1);
      cfg_r.rsz_h  <= bcr_pkg::DIM_W'(1);
      cfg_r.rsz_w  <= bcr_pkg::DIM_W'(1);
      cfg_r.crop_h <= bcr_pkg::DIM_W'(1);
      cfg_r.crop_w <= bcr_pkg::DIM_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        bcr_pkg::REG_SRC_H:  cfg_r.src_h  <= pwdata[bcr_pkg::DIM_W-1:0];
        bcr_pkg::REG_SRC_W:  cfg_r.src_w  <= pwdata[bcr_pkg::DIM_W-1:0];
        bcr_pkg::REG_CHN:    cfg_r.chn    <= pwdata[bcr_pkg::CH_W-1:0];
        bcr_pkg::REG_RSZ_H:  cfg_r.rsz_h  <= pwdata[bcr_pkg::DIM_W-1:0];
        bcr_pkg::REG_RSZ_W:  cfg_r.rsz_w  <= pwdata[bcr_pkg::DIM_W-1:0];
        bcr_pkg::REG_CROP_H: cfg_r.crop_h <= pwdata[bcr_pkg::DIM_W-1:0];
        bcr_pkg::REG_CROP_W: cfg_r.crop_w <= pwdata[bcr_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bcr_pkg::REG_SRC_H:  prdata = bcr_pkg::CFG_DATA_W'(cfg_r.src_h);
      bcr_pkg::REG_SRC_W:  prdata = bcr_pkg::CFG_DATA_W'(cfg_r.src_w);
      bcr_pkg::REG_CHN:    prdata = bcr_pkg::CFG_DATA_W'(cfg_r.chn);
      bcr_pkg::REG_RSZ_H:  prdata = bcr_pkg::CFG_DATA_W'(cfg_r.rsz_h);
      bcr_pkg::REG_RSZ_W:  prdata = bcr_pkg::CFG_DATA_W'(cfg_r.rsz_w);
      bcr_pkg::REG_CROP_H: prdata = bcr_pkg::CFG_DATA_W'(cfg_r.crop_h);
      bcr_pkg::REG_CROP_W: prdata = bcr_pkg::CFG_DATA_W'(cfg_r.crop_w);
      default:             prdata = '0;
    endcase
  end

  bcr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .push            (push),
    .full            (full),
    .in_opcode       (in_opcode),
    .in_source_index (in_source_index),
    .in_source_byte  (in_source_byte),
    .in_crop_column  (in_crop_column),
    .in_crop_row     (in_crop_row),
    .in_channel      (in_channel),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_full        (q_full)
  );

  bcr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (head),
    .q_empty (q_empty)
  );

  bcr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_pixel_out (out_pixel_out),
    .out_error     (out_error)
  );

endmodule
`default_nettype wire

// ===== hdl/bcr_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module bcr_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic [bcr_pkg::BYTE_W-1:0]  out_pixel_out,
  input wire logic                        out_error
);

  `BCR_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_pixel_out) && $stable(out_error))
  `BCR_ASSERT_SAME(a_err_zero, clk, rst_n, !empty && out_error, out_pixel_out == '0)
  `BCR_ASSERT_SAME(a_reset_empty, clk, rst_n, $past(!rst_n), empty)

endmodule

bind bilinear_crop_resize bcr_checker u_bcr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .empty         (empty),
  .pop           (pop),
  .out_pixel_out (out_pixel_out),
  .out_error     (out_error)
);
`default_nettype wire
